// File: sv/pbts_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbts_pkg
// Shared types and constants of the priority bitmap task scheduler: function
// and status codes, the command word broadcast to the task cells, the search
// token that walks the cell chain and the status each cell reports back.
// ----------------------------------------------------------------------------
package pbts_pkg;

	// widest values any legal parameter setting needs
	localparam int ID_W    = 6;
	localparam int PRIO_W  = 6;
	localparam int AGE_W   = 6;
	localparam int DLY_W   = 32;
	localparam int SLICE_W = 8;
	localparam int LOCK_W  = 8;

	localparam logic [SLICE_W-1:0] SLICE_RESET = 8'd10;
	localparam logic [LOCK_W-1:0]  LOCK_MAX    = 8'd255;

	// kernel function codes of an input word
	typedef enum logic [2:0] {
		FN_CREATE  = 3'd0,
		FN_TICK    = 3'd1,
		FN_DELAY   = 3'd2,
		FN_SUSPEND = 3'd3,
		FN_RESUME  = 3'd4,
		FN_LOCK    = 3'd5,
		FN_UNLOCK  = 3'd6,
		FN_NOP     = 3'd7
	} func_t;

	// result status codes
	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_LOCKED    = 2'd1,
		ST_NONE_RDY  = 2'd2,
		ST_NO_SCHED  = 2'd3
	} status_t;

	// operation broadcast to every cell
	typedef enum logic [2:0] {
		CMD_NONE    = 3'd0,
		CMD_CREATE  = 3'd1,
		CMD_SWEEP   = 3'd2,
		CMD_ROT     = 3'd3,
		CMD_DELAY   = 3'd4,
		CMD_SUSPEND = 3'd5,
		CMD_RESUME  = 3'd6
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t            kind;
		logic [ID_W-1:0]      id;
		logic [PRIO_W-1:0]    prio;
		logic [DLY_W-1:0]     dly;
		logic [SLICE_W-1:0]   slice_len;
	} cmd_t;

	// best ready task seen so far along the chain
	typedef struct packed {
		logic                 found;
		logic [PRIO_W-1:0]    prio;
		logic [AGE_W-1:0]     age;
		logic [ID_W-1:0]      id;
	} tok_t;

	// what a cell did with the current command
	typedef struct packed {
		logic                 enq;
		logic                 deq;
		logic                 hit;
		logic [AGE_W-1:0]     age;
	} cell_stat_t;

endpackage

// File: sv/pbts_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbts_req_if
// Request channel: one kernel call per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pbts_req_if;
	logic        valid;
	logic        ready;
	logic [2:0]  func;
	logic [3:0]  task_id;
	logic [4:0]  priority_req;
	logic [15:0] delay_ticks;

	modport source (output valid, func, task_id, priority_req, delay_ticks, input ready);
	modport sink   (input valid, func, task_id, priority_req, delay_ticks, output ready);
endinterface

// File: sv/pbts_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbts_rsp_if
// Result channel: one scheduling result per call, valid/ready handshake.
// ----------------------------------------------------------------------------
interface pbts_rsp_if;
	logic       valid;
	logic       ready;
	logic [3:0] next_task;
	logic       switch_request;
	logic [3:0] current_task;
	logic [1:0] status;

	modport source (output valid, next_task, switch_request, current_task, status,
		input ready);
	modport sink   (input valid, next_task, switch_request, current_task, status,
		output ready);
endinterface

// File: sv/pbts_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbts_cell
// One task slot. Holds the task's marks, priority, delay and slice counts and
// its queue age (rank among ready tasks, 0 is the newest). Passes the tick
// sweep token and the best-ready search token on to the next cell.
// ----------------------------------------------------------------------------
module pbts_cell #(
	parameter int CELL_ID    = 0,
	parameter int PRIO_BITS  = 5,
	parameter int AGE_BITS   = 4,
	parameter int DELAY_BITS = 16
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  pbts_pkg::cmd_t        cmd,
	input  logic                  sweep_in,
	output logic                  sweep_q,
	input  logic                  bump,
	input  logic                  deq_any,
	input  logic [AGE_BITS-1:0]   deq_age,
	input  pbts_pkg::tok_t        tok_in,
	output pbts_pkg::tok_t        tok_q,
	output pbts_pkg::cell_stat_t  stat
);

	logic                          created_q, delayed_q, susp_q;
	logic [PRIO_BITS-1:0]          prio_q;
	logic [DELAY_BITS-1:0]         delay_q;
	logic [pbts_pkg::SLICE_W-1:0]  slice_q;
	logic [AGE_BITS-1:0]           age_q;

	logic                          n_created, n_delayed, n_susp;
	logic [PRIO_BITS-1:0]          n_prio;
	logic [DELAY_BITS-1:0]         n_delay;
	logic [pbts_pkg::SLICE_W-1:0]  n_slice;
	logic [AGE_BITS-1:0]           n_age;
	logic                          enq, deq, hit_eff, dec;
	logic                          rdy, hit, better;

	assign rdy = created_q & ~delayed_q & ~susp_q;
	assign hit = (cmd.id == pbts_pkg::ID_W'(CELL_ID));
	assign dec = deq_any && (age_q > deq_age);

	// command decode and next state
	always_comb begin
		n_created = created_q;
		n_delayed = delayed_q;
		n_susp    = susp_q;
		n_prio    = prio_q;
		n_delay   = delay_q;
		n_slice   = slice_q;
		enq       = 1'b0;
		deq       = 1'b0;
		hit_eff   = 1'b0;
		unique case (cmd.kind)
			pbts_pkg::CMD_CREATE: begin
				if (hit && !created_q) begin
					n_created = 1'b1;
					n_delayed = 1'b0;
					n_susp    = 1'b0;
					n_delay   = '0;
					n_prio    = cmd.prio[PRIO_BITS-1:0];
					n_slice   = cmd.slice_len;
					enq       = 1'b1;
				end
			end
			pbts_pkg::CMD_SWEEP: begin
				if (sweep_in && created_q && delayed_q && !susp_q) begin
					if (delay_q != '0) begin
						n_delay = delay_q - 1'b1;
					end else begin
						n_delayed = 1'b0;
						enq       = 1'b1;
					end
				end
			end
			pbts_pkg::CMD_ROT: begin
				if (hit) begin
					if (slice_q <= 8'd1) begin
						n_slice = cmd.slice_len;
						if (rdy) begin
							deq = 1'b1;
							enq = 1'b1;
						end
					end else begin
						n_slice = slice_q - 1'b1;
					end
				end
			end
			pbts_pkg::CMD_DELAY: begin
				if (hit) begin
					deq       = rdy;
					n_delay   = cmd.dly[DELAY_BITS-1:0];
					n_delayed = 1'b1;
				end
			end
			pbts_pkg::CMD_SUSPEND: begin
				if (hit && created_q && !susp_q) begin
					hit_eff = 1'b1;
					deq     = rdy;
					n_susp  = 1'b1;
				end
			end
			pbts_pkg::CMD_RESUME: begin
				if (hit && created_q && susp_q) begin
					n_susp = 1'b0;
					enq    = !delayed_q;
				end
			end
			default: begin
			end
		endcase
		// queue order: newest is 0, others shift on enqueue and removal
		if (enq) begin
			n_age = '0;
		end else if (rdy && !deq) begin
			n_age = age_q + AGE_BITS'(bump) - AGE_BITS'(dec);
		end else begin
			n_age = age_q;
		end
	end

	assign stat.enq = enq;
	assign stat.deq = deq;
	assign stat.hit = hit_eff;
	assign stat.age = pbts_pkg::AGE_W'(age_q);

	// lower priority number wins, then the oldest entry
	assign better = rdy && (!tok_in.found ||
		(pbts_pkg::PRIO_W'(prio_q) < tok_in.prio) ||
		((pbts_pkg::PRIO_W'(prio_q) == tok_in.prio) &&
		 (pbts_pkg::AGE_W'(age_q) > tok_in.age)));

	// marks, sweep token and search token
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			created_q <= 1'b0;
			delayed_q <= 1'b0;
			susp_q    <= 1'b0;
			sweep_q   <= 1'b0;
			tok_q     <= '0;
		end else begin
			created_q <= n_created;
			delayed_q <= n_delayed;
			susp_q    <= n_susp;
			sweep_q   <= sweep_in;
			if (better) begin
				tok_q.found <= 1'b1;
				tok_q.prio  <= pbts_pkg::PRIO_W'(prio_q);
				tok_q.age   <= pbts_pkg::AGE_W'(age_q);
				tok_q.id    <= pbts_pkg::ID_W'(CELL_ID);
			end else begin
				tok_q <= tok_in;
			end
		end
	end

	// task payload
	always_ff @(posedge clk) begin
		prio_q  <= n_prio;
		delay_q <= n_delay;
		slice_q <= n_slice;
		age_q   <= n_age;
	end

endmodule

// File: sv/priority_bitmap_task_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// priority_bitmap_task_scheduler
// Task scheduler with one FIFO ready queue per priority and round robin
// inside a priority, built as a chain of per-task cells.
// ----------------------------------------------------------------------------
// One call is handled at a time and gives one result word. Create, suspend,
// resume and delay run in S_EXEC; when they end in a schedule step a search
// token walks the NUM_TASKS cells in S_SEARCH and the result is set in S_PICK.
// Lock, unlock and calls that schedule nothing finish without a search.
// A tick first passes a sweep token through all cells, one task per cycle,
// then runs the slice rotation in S_ROT and then the search. A new call
// is taken once the previous result word has been taken.
module priority_bitmap_task_scheduler #(
	parameter int NUM_TASKS  = 16,
	parameter int NUM_PRIO   = 32,
	parameter int DELAY_BITS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	pbts_req_if.sink                        req,
	pbts_rsp_if.source                      rsp,
	input  logic                            cfg_wr_en,
	input  logic [pbts_pkg::SLICE_W-1:0]    cfg_wr_data
);

	localparam int TW = $clog2(NUM_TASKS);
	localparam int PW = $clog2(NUM_PRIO);
	localparam logic [32:0] DLY_MAX = 33'((64'(1) << DELAY_BITS) - 64'(1));

	typedef enum logic [2:0] {
		S_IDLE, S_EXEC, S_SWEEP, S_ROT, S_SEARCH, S_PICK, S_WAIT
	} state_t;

	state_t                           state_q;
	logic [TW-1:0]                    cnt_q;
	pbts_pkg::func_t                  fn_q;
	logic [pbts_pkg::ID_W-1:0]        id_q;
	logic                             id_ok_q;
	logic [PW-1:0]                    prio_q;
	logic [DELAY_BITS-1:0]            dly_q;
	logic [pbts_pkg::SLICE_W-1:0]     slice_len_q;
	logic [pbts_pkg::LOCK_W-1:0]      lock_q;
	logic [TW-1:0]                    running_q;
	logic                             running_valid_q;
	logic [3:0]                       nx_q, cur_q;
	logic                             sw_q;
	pbts_pkg::status_t                status_q;

	pbts_pkg::cmd_t                   cmd;
	pbts_pkg::cell_stat_t             stat [NUM_TASKS];
	pbts_pkg::tok_t                   tok  [NUM_TASKS];
	logic [NUM_TASKS-1:0]             sweep_vec;
	logic [NUM_TASKS-1:0]             enq_vec;
	logic                             bump, deq_any, hit_any;
	logic [TW-1:0]                    deq_age;
	logic [pbts_pkg::AGE_W-1:0]       deq_age_w;
	logic                             sweep_start;
	logic                             sched_exec;
	pbts_pkg::tok_t                   best;
	logic [32:0]                      dly_in;

	assign dly_in = 33'(req.delay_ticks);
	assign best   = tok[NUM_TASKS-1];

	// slice length register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slice_len_q <= pbts_pkg::SLICE_RESET;
		end else if (cfg_wr_en) begin
			slice_len_q <= cfg_wr_data;
		end
	end

	// command broadcast to the cells
	always_comb begin
		cmd           = '0;
		cmd.kind      = pbts_pkg::CMD_NONE;
		cmd.id        = id_q;
		cmd.prio      = pbts_pkg::PRIO_W'(prio_q);
		cmd.dly       = pbts_pkg::DLY_W'(dly_q);
		cmd.slice_len = slice_len_q;
		unique case (state_q)
			S_EXEC: begin
				unique case (fn_q)
					pbts_pkg::FN_CREATE:  if (id_ok_q) cmd.kind = pbts_pkg::CMD_CREATE;
					pbts_pkg::FN_SUSPEND: if (id_ok_q) cmd.kind = pbts_pkg::CMD_SUSPEND;
					pbts_pkg::FN_RESUME:  if (id_ok_q) cmd.kind = pbts_pkg::CMD_RESUME;
					pbts_pkg::FN_DELAY: begin
						if (running_valid_q) begin
							cmd.kind = pbts_pkg::CMD_DELAY;
							cmd.id   = pbts_pkg::ID_W'(running_q);
						end
					end
					default: begin
					end
				endcase
			end
			S_SWEEP: cmd.kind = pbts_pkg::CMD_SWEEP;
			S_ROT: begin
				if (running_valid_q) begin
					cmd.kind = pbts_pkg::CMD_ROT;
					cmd.id   = pbts_pkg::ID_W'(running_q);
				end
			end
			default: begin
			end
		endcase
	end

	assign sweep_start = (state_q == S_SWEEP) && (cnt_q == '0);

	// cell chain
	for (genvar i = 0; i < NUM_TASKS; i++) begin : g_cell
		pbts_pkg::tok_t tok_prev;
		logic           sweep_prev;
		if (i == 0) begin : g_first
			assign tok_prev   = '0;
			assign sweep_prev = sweep_start;
		end else begin : g_next
			assign tok_prev   = tok[i-1];
			assign sweep_prev = sweep_vec[i-1];
		end
		pbts_cell #(
			.CELL_ID    (i),
			.PRIO_BITS  (PW),
			.AGE_BITS   (TW),
			.DELAY_BITS (DELAY_BITS)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.cmd      (cmd),
			.sweep_in (sweep_prev),
			.sweep_q  (sweep_vec[i]),
			.bump     (bump),
			.deq_any  (deq_any),
			.deq_age  (deq_age),
			.tok_in   (tok_prev),
			.tok_q    (tok[i]),
			.stat     (stat[i])
		);
		assign enq_vec[i] = stat[i].enq;
	end

	// gather cell status
	always_comb begin
		deq_any   = 1'b0;
		hit_any   = 1'b0;
		deq_age_w = '0;
		for (int i = 0; i < NUM_TASKS; i++) begin
			deq_any   = deq_any | stat[i].deq;
			hit_any   = hit_any | stat[i].hit;
			deq_age_w = deq_age_w | (stat[i].age & {pbts_pkg::AGE_W{stat[i].deq}});
		end
	end

	assign bump    = |enq_vec;
	assign deq_age = deq_age_w[TW-1:0];

	// does the single-step call end in a schedule step
	assign sched_exec = (fn_q == pbts_pkg::FN_DELAY) ||
		((fn_q == pbts_pkg::FN_SUSPEND) && hit_any && running_valid_q &&
		 (pbts_pkg::ID_W'(running_q) == id_q));

	assign req.ready          = (state_q == S_IDLE);
	assign rsp.valid          = (state_q == S_WAIT);
	assign rsp.next_task      = nx_q;
	assign rsp.switch_request = sw_q;
	assign rsp.current_task   = cur_q;
	assign rsp.status         = status_q;

	// call sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			cnt_q           <= '0;
			fn_q            <= pbts_pkg::FN_NOP;
			id_q            <= '0;
			id_ok_q         <= 1'b0;
			prio_q          <= '0;
			dly_q           <= '0;
			lock_q          <= '0;
			running_q       <= '0;
			running_valid_q <= 1'b0;
			nx_q            <= '0;
			cur_q           <= '0;
			sw_q            <= 1'b0;
			status_q        <= pbts_pkg::ST_NO_SCHED;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req.valid) begin
						fn_q     <= pbts_pkg::func_t'(req.func);
						id_q     <= pbts_pkg::ID_W'(req.task_id);
						id_ok_q  <= (32'(req.task_id) < NUM_TASKS);
						prio_q   <= (32'(req.priority_req) >= NUM_PRIO) ?
							PW'(NUM_PRIO - 1) : PW'(req.priority_req);
						dly_q    <= (dly_in > DLY_MAX) ? DELAY_BITS'(DLY_MAX) :
							DELAY_BITS'(dly_in);
						cnt_q    <= '0;
						nx_q     <= '0;
						sw_q     <= 1'b0;
						cur_q    <= 4'(running_q);
						status_q <= pbts_pkg::ST_NO_SCHED;
						unique case (pbts_pkg::func_t'(req.func))
							pbts_pkg::FN_TICK: state_q <= S_SWEEP;
							pbts_pkg::FN_CREATE, pbts_pkg::FN_DELAY,
							pbts_pkg::FN_SUSPEND, pbts_pkg::FN_RESUME: state_q <= S_EXEC;
							pbts_pkg::FN_LOCK: begin
								if (lock_q != pbts_pkg::LOCK_MAX) lock_q <= lock_q + 1'b1;
								state_q <= S_WAIT;
							end
							pbts_pkg::FN_UNLOCK: begin
								if (lock_q != '0) lock_q <= lock_q - 1'b1;
								state_q <= S_WAIT;
							end
							default: state_q <= S_WAIT;
						endcase
					end
				end
				S_EXEC: begin
					if (!sched_exec) begin
						state_q <= S_WAIT;
					end else if (lock_q != '0) begin
						status_q <= pbts_pkg::ST_LOCKED;
						state_q  <= S_WAIT;
					end else begin
						cnt_q   <= '0;
						state_q <= S_SEARCH;
					end
				end
				S_SWEEP: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == TW'(NUM_TASKS - 1)) state_q <= S_ROT;
				end
				S_ROT: begin
					cnt_q <= '0;
					if (lock_q != '0) begin
						status_q <= pbts_pkg::ST_LOCKED;
						state_q  <= S_WAIT;
					end else begin
						state_q <= S_SEARCH;
					end
				end
				S_SEARCH: begin
					cnt_q <= cnt_q + 1'b1;
					if (cnt_q == TW'(NUM_TASKS - 1)) state_q <= S_PICK;
				end
				S_PICK: begin
					if (!best.found) begin
						status_q <= pbts_pkg::ST_NONE_RDY;
					end else begin
						status_q        <= pbts_pkg::ST_OK;
						nx_q            <= 4'(best.id);
						sw_q            <= !running_valid_q ||
							(best.id != pbts_pkg::ID_W'(running_q));
						running_q       <= TW'(best.id);
						running_valid_q <= 1'b1;
						cur_q           <= 4'(best.id);
					end
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (rsp.ready) state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// a call is never taken while a result word is on offer
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(req.ready && rsp.valid)) else $error("call taken while result pending");

	// a switch comes only from a successful schedule step
	a_switch_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.switch_request) |-> (rsp.status == pbts_pkg::ST_OK))
		else $error("switch without ok status");

	// at most one task enters a queue per cycle
	a_one_enq: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(enq_vec)) else $error("several tasks enqueued at once");

	// a found head leaves a valid running task
	a_pick_runs: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PICK && best.found) |=> running_valid_q)
		else $error("pick left no running task");

endmodule

// File: tb/pbts_sched_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pbts_sched_checker
// Watches the call and result channels of the task scheduler. It keeps its
// own copy of the ready queues, delays, suspend marks and slices, works out
// the result word of every accepted call and compares it, field by field,
// with the oldest expected result when a result word is taken.
// ----------------------------------------------------------------------------
module pbts_sched_checker (
	input  logic       clk,
	input  logic       arst_n,
	pbts_req_if        req,
	pbts_rsp_if        rsp,
	input  logic       cfg_wr_en,
	input  logic [7:0] cfg_wr_data,
	output int         errors,
	output int         pending
);
	import pbts_pkg::*;

	localparam int NT = 16;
	localparam int NP = 32;

	typedef struct packed {
		logic [3:0] next_task;
		logic       switch_request;
		logic [3:0] current_task;
		status_t    status;
	} sched_word_t;

	sched_word_t expected_words[$];

	// scheduler image
	logic [7:0]  slice_len;
	logic [4:0]  prio_of [NT];
	logic        created [NT];
	logic        delayed [NT];
	logic        suspended [NT];
	logic [15:0] ticks_left [NT];
	logic [7:0]  slice_left [NT];
	logic [3:0]  link [NT];
	logic [3:0]  q_head [NP];
	logic [3:0]  q_tail [NP];
	logic [31:0] prio_map;
	logic [3:0]  running;
	logic        running_ok;
	logic [7:0]  locks;

	function automatic logic is_ready(input int t);
		return created[t] && !delayed[t] && !suspended[t];
	endfunction

	function automatic void queue_push(input int t);
		int p;
		p = prio_of[t];
		if (!prio_map[p]) begin
			q_head[p] = 4'(t);
			q_tail[p] = 4'(t);
			prio_map[p] = 1'b1;
		end else begin
			link[q_tail[p]] = 4'(t);
			q_tail[p] = 4'(t);
		end
	endfunction

	function automatic void queue_unlink(input int t);
		int p;
		int prev;
		p = prio_of[t];
		if (!prio_map[p]) return;
		if (q_head[p] == t) begin
			if (q_tail[p] == t) prio_map[p] = 1'b0;
			else q_head[p] = link[t];
			return;
		end
		prev = q_head[p];
		for (int n = 0; n < NT && prev != q_tail[p]; n++) begin
			if (link[prev] == t) begin
				link[prev] = link[t];
				if (q_tail[p] == t) q_tail[p] = 4'(prev);
				return;
			end
			prev = link[prev];
		end
	endfunction

	// pick the head of the best non-empty queue, or report the lock
	function automatic void pick_next(inout sched_word_t w);
		if (locks != 0) begin
			w.status = ST_LOCKED;
			return;
		end
		for (int p = 0; p < NP; p++) begin
			if (prio_map[p]) begin
				w.next_task = q_head[p];
				if (!running_ok || q_head[p] != running) begin
					running = q_head[p];
					running_ok = 1'b1;
					w.switch_request = 1'b1;
				end
				w.status = ST_OK;
				return;
			end
		end
		w.status = ST_NONE_RDY;
	endfunction

	function automatic void tick_tasks();
		int t;
		for (t = 0; t < NT; t++) begin
			if (!created[t] || !delayed[t] || suspended[t]) continue;
			if (ticks_left[t] > 0) ticks_left[t]--;
			else begin
				delayed[t] = 1'b0;
				queue_push(t);
			end
		end
		// time slice of the running task
		if (running_ok) begin
			t = running;
			if (slice_left[t] <= 1) begin
				slice_left[t] = slice_len;
				if (is_ready(t)) begin
					queue_unlink(t);
					queue_push(t);
				end
			end else slice_left[t]--;
		end
	endfunction

	function automatic sched_word_t predict_word(input logic [2:0] fn, input logic [3:0] id,
			input logic [4:0] prio, input logic [15:0] dly);
		sched_word_t w;
		w = '{next_task: 4'd0, switch_request: 1'b0, current_task: 4'd0,
			status: ST_NO_SCHED};
		case (func_t'(fn))
			FN_CREATE: begin
				if (!created[id]) begin
					prio_of[id] = prio;
					created[id] = 1'b1;
					delayed[id] = 1'b0;
					suspended[id] = 1'b0;
					ticks_left[id] = '0;
					slice_left[id] = slice_len;
					queue_push(id);
				end
			end
			FN_TICK: begin
				tick_tasks();
				pick_next(w);
			end
			FN_DELAY: begin
				if (running_ok) begin
					if (is_ready(running)) queue_unlink(running);
					ticks_left[running] = dly;
					delayed[running] = 1'b1;
				end
				pick_next(w);
			end
			FN_SUSPEND: begin
				if (created[id] && !suspended[id]) begin
					if (is_ready(id)) queue_unlink(id);
					suspended[id] = 1'b1;
					if (running_ok && running == id) pick_next(w);
				end
			end
			FN_RESUME: begin
				if (created[id] && suspended[id]) begin
					suspended[id] = 1'b0;
					if (!delayed[id]) queue_push(id);
				end
			end
			FN_LOCK: if (locks != LOCK_MAX) locks++;
			FN_UNLOCK: if (locks != 0) locks--;
			default: ;
		endcase
		w.current_task = running;
		return w;
	endfunction

	// predict on every accepted call, compare on every taken result
	always @(posedge clk or negedge arst_n) begin
		sched_word_t want;
		sched_word_t got;
		if (!arst_n) begin
			slice_len = SLICE_RESET;
			for (int t = 0; t < NT; t++) begin
				created[t] = 1'b0;
				delayed[t] = 1'b0;
				suspended[t] = 1'b0;
			end
			prio_map = '0;
			running = '0;
			running_ok = 1'b0;
			locks = '0;
			expected_words.delete();
			errors <= 0;
			pending <= 0;
		end else begin
			if (cfg_wr_en) slice_len = cfg_wr_data;
			if (req.valid && req.ready)
				expected_words.push_back(predict_word(req.func, req.task_id,
					req.priority_req, req.delay_ticks));
			if (rsp.valid && rsp.ready) begin
				got = '{next_task: rsp.next_task, switch_request: rsp.switch_request,
					current_task: rsp.current_task, status: status_t'(rsp.status)};
				if (expected_words.size() == 0) begin
					$display("%0t: result word with none expected: %p", $time, got);
					errors <= errors + 1;
				end else begin
					want = expected_words.pop_front();
					if (got !== want) begin
						$display("%0t: result mismatch: expected %p actual %p",
							$time, want, got);
						errors <= errors + 1;
					end
				end
			end
			pending <= expected_words.size();
		end
	end
endmodule

// File: tb/tb_priority_bitmap_task_scheduler.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_priority_bitmap_task_scheduler
// Drives kernel calls into the task scheduler under random idling on both
// channels and across several slice lengths; the checker beside the block
// predicts and compares every result word.
// ----------------------------------------------------------------------------
module tb_priority_bitmap_task_scheduler;
	import pbts_pkg::*;

	localparam int CYCLE_LIMIT = 1000000;

	logic       clk;
	logic       arst_n;
	logic       cfg_wr_en;
	logic [7:0] cfg_wr_data;
	logic       no_idle;
	int         errors;
	int         pending;
	int         cycles;
	int         stall_left;
	logic [3:0] last_running;

	pbts_req_if req ();
	pbts_rsp_if rsp ();

	priority_bitmap_task_scheduler u_top (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	pbts_sched_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req),
		.rsp         (rsp),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data),
		.errors      (errors),
		.pending     (pending)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// watchdog
	initial cycles = 0;
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// result side stalls in bursts
	initial begin
		rsp.ready = 1'b0;
		stall_left = 0;
	end
	always @(posedge clk) begin
		if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			rsp.ready <= 1'b0;
		end else if (!no_idle && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 4);
			rsp.ready <= 1'b0;
		end else begin
			rsp.ready <= 1'b1;
		end
	end

	// running task as last reported, to aim suspends at it
	initial last_running = '0;
	always @(posedge clk) if (rsp.valid && rsp.ready) last_running <= rsp.current_task;

	task automatic send_word(input func_t fn, input logic [3:0] id, input logic [4:0] prio,
			input logic [15:0] dly);
		req.func <= fn;
		req.task_id <= id;
		req.priority_req <= prio;
		req.delay_ticks <= dly;
		req.valid <= 1'b1;
		do @(posedge clk); while (!req.ready);
		if (!no_idle && $urandom_range(0, 5) == 0) begin
			req.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
	endtask

	// call with random unused fields
	task automatic send_any(input func_t fn);
		send_word(fn, 4'($urandom), 5'($urandom), 16'($urandom));
	endtask

	task automatic drain_and_set_slice(input logic [7:0] len);
		req.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= len;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
	endtask

	task automatic random_call();
		int pick;
		logic [15:0] dly;
		pick = $urandom_range(0, 99);
		if (pick < 12)
			send_word(FN_CREATE, 4'($urandom_range(0, 15)),
				($urandom_range(0, 9) < 7) ? 5'($urandom_range(0, 3)) :
				5'($urandom_range(0, 31)), 16'($urandom));
		else if (pick < 55)
			send_any(FN_TICK);
		else if (pick < 67) begin
			if ($urandom_range(0, 79) == 0) dly = 16'($urandom);
			else if ($urandom_range(0, 9) == 0) dly = 16'($urandom_range(0, 300));
			else dly = 16'($urandom_range(0, 8));
			send_word(FN_DELAY, 4'($urandom), 5'($urandom), dly);
		end else if (pick < 77)
			send_word(FN_SUSPEND,
				($urandom_range(0, 1) != 0) ? last_running : 4'($urandom_range(0, 15)),
				5'($urandom), 16'($urandom));
		else if (pick < 89)
			send_word(FN_RESUME, 4'($urandom_range(0, 15)), 5'($urandom), 16'($urandom));
		else if (pick < 93)
			send_any(FN_LOCK);
		else if (pick < 99)
			send_any(FN_UNLOCK);
		else
			send_any(FN_NOP);
	endtask

	initial begin
		arst_n = 1'b0;
		no_idle = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = '0;
		req.valid = 1'b0;
		req.func = FN_NOP;
		req.task_id = '0;
		req.priority_req = '0;
		req.delay_ticks = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty scheduler, then corner calls
		send_word(FN_TICK, 4'd0, 5'd0, 16'd0);
		send_word(FN_DELAY, 4'd0, 5'd0, 16'd5);
		send_word(FN_UNLOCK, 4'd0, 5'd0, 16'd0);
		send_word(FN_NOP, 4'hf, 5'h1f, 16'hffff);
		send_word(FN_SUSPEND, 4'd3, 5'd0, 16'd0);
		send_word(FN_CREATE, 4'd15, 5'd31, 16'hffff);
		send_word(FN_CREATE, 4'd0, 5'd0, 16'd0);
		send_word(FN_CREATE, 4'd0, 5'd7, 16'd0);
		send_word(FN_CREATE, 4'd1, 5'd0, 16'd0);
		send_word(FN_TICK, 4'd0, 5'd0, 16'd0);
		send_word(FN_LOCK, 4'd0, 5'd0, 16'd0);
		send_word(FN_TICK, 4'd0, 5'd0, 16'd0);
		send_word(FN_UNLOCK, 4'd0, 5'd0, 16'd0);
		send_word(FN_DELAY, 4'd0, 5'd0, 16'd2);
		send_word(FN_SUSPEND, last_running, 5'd0, 16'd0);
		send_word(FN_SUSPEND, 4'd1, 5'd0, 16'd0);
		send_word(FN_RESUME, 4'd0, 5'd0, 16'd0);
		send_word(FN_RESUME, 4'd1, 5'd0, 16'd0);
		send_word(FN_RESUME, 4'd1, 5'd0, 16'd0);
		send_word(FN_TICK, 4'd0, 5'd0, 16'd0);
		send_word(FN_DELAY, 4'd0, 5'd0, 16'hffff);
		send_word(FN_TICK, 4'd0, 5'd0, 16'd0);

		// lock count saturation and unwind
		drain_and_set_slice(8'd1);
		repeat (258) send_any(FN_LOCK);
		send_word(FN_TICK, 4'd0, 5'd0, 16'd0);
		repeat (258) send_any(FN_UNLOCK);

		repeat (220) random_call();
		drain_and_set_slice(8'd255);
		repeat (220) random_call();
		drain_and_set_slice(8'd3);
		repeat (220) random_call();
		drain_and_set_slice(8'd2);
		no_idle = 1'b1;
		repeat (220) random_call();
		req.valid <= 1'b0;

		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (60) @(posedge clk);
		if (errors == 0) $display("RESULT: OK");
		else $display("RESULT: ERROR");
		$finish;
	end
endmodule

// File: sim.f
sv/pbts_pkg.sv
sv/pbts_req_if.sv
sv/pbts_rsp_if.sv
sv/pbts_cell.sv
sv/priority_bitmap_task_scheduler.sv
tb/pbts_sched_checker.sv
tb/tb_priority_bitmap_task_scheduler.sv
